/* rtl/blrt_pkg.sv */
// Shared types and constants for the best and recent lap table.
package blrt_pkg;

	localparam int unsigned NumberW = 8;
	localparam int unsigned TimeW = 24;
	localparam int unsigned IndexW = 3;
	localparam int unsigned RankOutW = 4;
	localparam int unsigned DefListDepth = 8;
	localparam int unsigned ReadSlots = 8;

	// In-band item kinds carried on tuser
	localparam logic CmdRecord = 1'b0;
	localparam logic CmdRead = 1'b1;

	localparam int unsigned InDataW = 40;
	localparam int unsigned OutDataW = 72;

	typedef struct packed {
		logic [TimeW-1:0] lap_time;
		logic [NumberW-1:0] lap_number;
	} lap_entry_t;

endpackage

/* rtl/blrt_cell.sv */
// One slot of both lap lists: a recent-history stage and a best-time stage.
module blrt_cell import blrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic record,
	input lap_entry_t lap,
	input lap_entry_t recent_prev,
	input lap_entry_t best_prev,
	input logic found_in,
	output lap_entry_t recent,
	output lap_entry_t best,
	output logic found_out,
	output logic take
);

	lap_entry_t recent_q;
	lap_entry_t best_q;
	logic fits;

	// Slot is a candidate when the lap is faster or the slot is empty
	assign fits = (lap.lap_time < best_q.lap_time) || (best_q.lap_time == '0);
	assign take = fits && !found_in;
	assign found_out = found_in || fits;
	assign recent = recent_q;
	assign best = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			best_q <= '0;
		end else if (record) begin
			recent_q <= recent_prev;
			if (found_in) begin
				best_q <= best_prev;
			end else if (fits) begin
				best_q <= lap;
			end
		end
	end

endmodule

/* rtl/best_and_recent_lap_table.sv */
// Top level of the best and recent lap table: a row of list cells and a result register.
//
// The block holds LIST_DEPTH cells, each storing one slot of the recent-history
// list and one slot of the ascending best-time list; both lists are empty after
// reset (a time of zero means an empty slot). A record item (tuser = 0) pushes
// the lap onto the front of the recent list and inserts it into the best list at
// the first slot whose time is larger or empty, placing it after equal times and
// dropping the last entry. A read item (tuser = 1) leaves both lists alone. Every
// item yields exactly one result, which reports the best-list slot taken (or
// LIST_DEPTH, modulo 16, when not placed or on a read) and both lists' entries at
// read_index after the update; an index at or past LIST_DEPTH reads as zero, and
// only the first eight slots can be read back. The result is registered at the
// edge that accepts the item and shows the next cycle, and a new item is taken
// every cycle as long as results are drained. The clock period is set by the
// insertion-point chain that ripples through all cells.
module best_and_recent_lap_table import blrt_pkg::*; #(
	parameter int unsigned LIST_DEPTH = DefListDepth
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [7:0] lap_number, [31:8] lap_time, [34:32] read_index, [39:35] zero
	input logic [InDataW-1:0] s_axis_tdata,
	// [0] cmd
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [3:0] top_rank, [11:4] recent_number, [35:12] recent_time,
	// [43:36] best_number, [67:44] best_time, [71:68] zero
	output logic [OutDataW-1:0] m_axis_tdata
);

	localparam int unsigned RankW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned ReadN = (LIST_DEPTH < ReadSlots) ? LIST_DEPTH : ReadSlots;

	lap_entry_t lap;
	logic [IndexW-1:0] read_index;
	logic accept;
	logic record;

	lap_entry_t recent_cell [LIST_DEPTH];
	lap_entry_t best_cell [LIST_DEPTH];
	logic found_chain [LIST_DEPTH+1];
	logic [LIST_DEPTH-1:0] take;

	logic [RankW-1:0] rank_nxt;
	logic [RankW-1:0] rank_q;
	logic [IndexW-1:0] idx_q;
	logic out_valid_q;

	lap_entry_t recent_sel;
	lap_entry_t best_sel;
	logic [RankW+RankOutW-1:0] rank_ext;

	// Unpack the incoming item
	assign lap.lap_number = s_axis_tdata[NumberW-1:0];
	assign lap.lap_time = s_axis_tdata[NumberW+TimeW-1:NumberW];
	assign read_index = s_axis_tdata[NumberW+TimeW+IndexW-1:NumberW+TimeW];

	// Take a new item whenever the result register is free or drains this cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign record = accept && (s_axis_tuser == CmdRecord);

	assign found_chain[0] = 1'b0;

	// Cell 0 takes the new lap from both sides; later cells take their neighbor's
	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		if (k == 0) begin : g_head
			blrt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.record(record),
				.lap(lap),
				.recent_prev(lap),
				.best_prev(lap),
				.found_in(found_chain[k]),
				.recent(recent_cell[k]),
				.best(best_cell[k]),
				.found_out(found_chain[k+1]),
				.take(take[k])
			);
		end else begin : g_body
			blrt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.record(record),
				.lap(lap),
				.recent_prev(recent_cell[k-1]),
				.best_prev(best_cell[k-1]),
				.found_in(found_chain[k]),
				.recent(recent_cell[k]),
				.best(best_cell[k]),
				.found_out(found_chain[k+1]),
				.take(take[k])
			);
		end
	end

	// At most one cell takes the lap; encode its slot, or report the depth
	always_comb begin
		rank_nxt = '0;
		for (int k = 0; k < LIST_DEPTH; k++) begin
			if (take[k]) begin
				rank_nxt = rank_nxt | RankW'(k);
			end
		end
		if (!found_chain[LIST_DEPTH]) begin
			rank_nxt = RankW'(LIST_DEPTH);
		end
	end

	// Hold the rank and the read index; the lists hold still while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rank_q <= (s_axis_tuser == CmdRecord) ? rank_nxt : RankW'(LIST_DEPTH);
			idx_q <= read_index;
		end
	end

	// Read back both lists at the held index; out-of-range indexes read as empty
	always_comb begin
		recent_sel = '0;
		best_sel = '0;
		for (int k = 0; k < ReadN; k++) begin
			if (idx_q == IndexW'(k)) begin
				recent_sel = recent_cell[k];
				best_sel = best_cell[k];
			end
		end
	end

	assign rank_ext = {{RankOutW{1'b0}}, rank_q};

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {
		4'b0000,
		best_sel.lap_time,
		best_sel.lap_number,
		recent_sel.lap_time,
		recent_sel.lap_number,
		rank_ext[RankOutW-1:0]
	};

endmodule

/* rtl/blrt_checker.sv */
// Port-level checks for the best and recent lap table, bound to the top level.
module blrt_checker import blrt_pkg::*; #(
	parameter int unsigned LIST_DEPTH = DefListDepth
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata
);

	localparam logic [RankOutW-1:0] DepthRank = RankOutW'(LIST_DEPTH);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Every accepted item shows its result on the next cycle
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted item gave no result");

	// Input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with no waiting result");

	// A read item never reports a placement
	a_read_rank: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CmdRead)
		|=> m_axis_tdata[RankOutW-1:0] == DepthRank)
		else $error("read item reported a rank");

endmodule

bind best_and_recent_lap_table blrt_checker #(.LIST_DEPTH(LIST_DEPTH)) u_blrt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
